// File: rtl/core/vtd_pkg.sv
// Shared types, constants and control structs for the vertex triple dedup table.
package vtd_pkg;

  // Default sizes of the table and of the stored index words.
  localparam int unsigned DefTableDepth = 256;
  localparam int unsigned DefRefBits    = 16;

  // Fixed widths of the port fields.
  localparam int unsigned FieldW = 16;
  localparam int unsigned SlotW  = 8;

  // One face corner on the input side.
  typedef struct packed {
    logic              start_mesh;
    logic [FieldW-1:0] position_ref;
    logic [FieldW-1:0] texcoord_ref;
    logic [FieldW-1:0] normal_ref;
  } in_beat_t;

  // One result on the output side.
  typedef struct packed {
    logic [SlotW-1:0]  vertex_slot;
    logic              is_new;
    logic              overflow;
    logic [FieldW-1:0] position_zero;
    logic [FieldW-1:0] texcoord_zero;
    logic [FieldW-1:0] normal_zero;
  } out_beat_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;  // capture the corner and clear the table on start
    logic scan;  // step the table search
    logic emit;  // finish the corner and load the output register
  } ctrl_cmd_t;

  // Status from the datapath back to the controller.
  typedef struct packed {
    logic hit;       // the entry under compare matches
    logic exhausted; // every valid entry has been compared
    logic out_free;  // the output register can take a beat this cycle
  } dp_status_t;

endpackage

// File: rtl/core/vtd_ram.sv
// Generic single-write, single-read RAM with a registered read port.
module vtd_ram #(
  parameter int unsigned WIDTH = 48,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     wr_en_i,
  input  logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  logic [WIDTH-1:0]         wr_data_i,
  input  logic                     rd_en_i,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_i,
  output logic [WIDTH-1:0]         rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write port.
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  // Registered read port.
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_o <= mem_q[rd_addr_i];
    end
  end

endmodule

// File: rtl/core/vtd_ctrl.sv
// Controller state machine that sequences load, table search and result for each corner.
module vtd_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  vtd_pkg::dp_status_t status_i,
  output vtd_pkg::ctrl_cmd_t  cmd_o
);

  typedef enum logic [1:0] {
    StIdle,
    StScan,
    StFinish
  } state_e;

  state_e state_q, state_d;

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          state_d = StScan;
        end
      end
      StScan: begin
        if (status_i.hit || status_i.exhausted) begin
          state_d = StFinish;
        end
      end
      StFinish: begin
        if (status_i.out_free) begin
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  // Commands decoded from the current state.
  assign in_ready_o = (state_q == StIdle);
  assign cmd_o.load = (state_q == StIdle) && in_valid_i;
  assign cmd_o.scan = (state_q == StScan);
  assign cmd_o.emit = (state_q == StFinish) && status_i.out_free;

endmodule

// File: rtl/core/vtd_datapath.sv
// Datapath: index conversion, table storage, one-entry-per-cycle search and output register.
module vtd_datapath #(
  parameter int unsigned TABLE_DEPTH = vtd_pkg::DefTableDepth,
  parameter int unsigned REF_BITS    = vtd_pkg::DefRefBits
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  vtd_pkg::in_beat_t   in_beat_i,
  input  vtd_pkg::ctrl_cmd_t  cmd_i,
  output vtd_pkg::dp_status_t status_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output vtd_pkg::out_beat_t  out_beat_o
);

  localparam int unsigned IdxW     = $clog2(TABLE_DEPTH);
  localparam int unsigned CntW     = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned EntryW   = 3 * REF_BITS;
  localparam int unsigned RefExtW  = (REF_BITS > vtd_pkg::FieldW) ? REF_BITS : vtd_pkg::FieldW;
  localparam int unsigned SlotExtW = (CntW > vtd_pkg::SlotW) ? CntW : vtd_pkg::SlotW;

  logic [REF_BITS-1:0] pos_q, tex_q, nrm_q;
  logic [REF_BITS-1:0] pos_d, tex_d, nrm_d;
  logic [CntW-1:0]     count_q, scan_q, cmp_idx_q, found_slot_q;
  logic                cmp_valid_q, found_q, out_valid_q;
  vtd_pkg::out_beat_t  out_q;
  logic [EntryW-1:0]   rd_data;
  logic                rd_en, wr_en, full, match;

  // Convert one-based input index to a zero-based REF_BITS value.
  function automatic logic [REF_BITS-1:0] to_zero(input logic [vtd_pkg::FieldW-1:0] ref_v);
    logic [RefExtW-1:0] ext;
    ext = RefExtW'(ref_v) - RefExtW'(1);
    return ext[REF_BITS-1:0];
  endfunction

  // Fit a stored index onto an output field.
  function automatic logic [vtd_pkg::FieldW-1:0] to_field(input logic [REF_BITS-1:0] val);
    logic [RefExtW-1:0] ext;
    ext = RefExtW'(val);
    return ext[vtd_pkg::FieldW-1:0];
  endfunction

  // Fit a slot number onto the output slot field.
  function automatic logic [vtd_pkg::SlotW-1:0] to_slot(input logic [CntW-1:0] val);
    logic [SlotExtW-1:0] ext;
    ext = SlotExtW'(val);
    return ext[vtd_pkg::SlotW-1:0];
  endfunction

  assign pos_d = to_zero(in_beat_i.position_ref);
  assign tex_d = to_zero(in_beat_i.texcoord_ref);
  assign nrm_d = to_zero(in_beat_i.normal_ref);

  assign full  = (count_q == CntW'(TABLE_DEPTH));
  assign match = cmp_valid_q && (rd_data == {pos_q, tex_q, nrm_q});

  // Issue a read while searching and entries remain unread, unless a match ends the search.
  assign rd_en = cmd_i.scan && !match && (scan_q < count_q);
  assign wr_en = cmd_i.emit && !found_q && !full;

  vtd_ram #(
    .WIDTH(EntryW),
    .DEPTH(TABLE_DEPTH)
  ) u_table (
    .clk_i    (clk_i),
    .wr_en_i  (wr_en),
    .wr_addr_i(count_q[IdxW-1:0]),
    .wr_data_i({pos_q, tex_q, nrm_q}),
    .rd_en_i  (rd_en),
    .rd_addr_i(scan_q[IdxW-1:0]),
    .rd_data_o(rd_data)
  );

  // Captured corner, held for the whole search.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      pos_q <= pos_d;
      tex_q <= tex_d;
      nrm_q <= nrm_d;
    end
  end

  // Search control: fill count, read pointer, compare stage and hit capture.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q      <= '0;
      scan_q       <= '0;
      cmp_idx_q    <= '0;
      cmp_valid_q  <= 1'b0;
      found_q      <= 1'b0;
      found_slot_q <= '0;
    end else if (cmd_i.load) begin
      if (in_beat_i.start_mesh) begin
        count_q <= '0;
      end
      scan_q      <= '0;
      cmp_valid_q <= 1'b0;
      found_q     <= 1'b0;
    end else if (cmd_i.scan) begin
      if (match) begin
        found_q      <= 1'b1;
        found_slot_q <= cmp_idx_q;
        cmp_valid_q  <= 1'b0;
      end else begin
        cmp_valid_q <= rd_en;
        cmp_idx_q   <= scan_q;
        if (rd_en) begin
          scan_q <= scan_q + CntW'(1);
        end
      end
    end else if (wr_en) begin
      count_q <= count_q + CntW'(1);
    end
  end

  // Output register: loaded on emit, released when the beat is taken.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_q.position_zero <= to_field(pos_q);
      out_q.texcoord_zero <= to_field(tex_q);
      out_q.normal_zero   <= to_field(nrm_q);
      if (found_q) begin
        out_q.vertex_slot <= to_slot(found_slot_q);
        out_q.is_new      <= 1'b0;
        out_q.overflow    <= 1'b0;
      end else if (!full) begin
        out_q.vertex_slot <= to_slot(count_q);
        out_q.is_new      <= 1'b1;
        out_q.overflow    <= 1'b0;
      end else begin
        out_q.vertex_slot <= '0;
        out_q.is_new      <= 1'b0;
        out_q.overflow    <= 1'b1;
      end
    end
  end

  assign status_o.hit       = match;
  assign status_o.exhausted = !cmp_valid_q && (scan_q >= count_q);
  assign status_o.out_free  = !out_valid_q || out_ready_i;

  assign out_valid_o = out_valid_q;
  assign out_beat_o  = out_q;

endmodule

// File: rtl/core/vertex_triple_dedup_table_core.sv
// Top level of the vertex triple dedup table: controller, datapath and checks.
// Each accepted face corner is made zero-based and looked up in a table of the
// distinct triples of the current mesh. The table is searched in insertion
// order, one entry per clock, through its single read port. A miss appends the
// triple unless the table is full. One corner is handled at a time. The
// controller returns to idle as the result is loaded into the output register,
// so the next corner can be accepted in the cycle after. A result that still
// waits for out_ready_i holds the next result back at the end of its search.
// start_mesh empties the table before its corner is looked up. A miss on a full
// table stores nothing and returns overflow with slot 0.
module vertex_triple_dedup_table_core #(
  parameter int unsigned TABLE_DEPTH = vtd_pkg::DefTableDepth,
  parameter int unsigned REF_BITS    = vtd_pkg::DefRefBits
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  vtd_pkg::in_beat_t  in_beat_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output vtd_pkg::out_beat_t out_beat_o
);

  vtd_pkg::ctrl_cmd_t  cmd;
  vtd_pkg::dp_status_t status;

  // Sequencer.
  vtd_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_ready_o(in_ready_o),
    .status_i  (status),
    .cmd_o     (cmd)
  );

  // Table, search and output register.
  vtd_datapath #(
    .TABLE_DEPTH(TABLE_DEPTH),
    .REF_BITS   (REF_BITS)
  ) u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_beat_i  (in_beat_i),
    .cmd_i      (cmd),
    .status_o   (status),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_beat_o (out_beat_o)
  );

`ifndef SYNTH
  // A corner is never accepted while the previous one is still being looked up.
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("input accepted on two consecutive cycles");

  // A new vertex and an overflow never come together.
  a_new_or_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(out_beat_o.is_new && out_beat_o.overflow))
    else $error("result flags both is_new and overflow");

  // An overflow result carries slot zero.
  a_overflow_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_beat_o.overflow) |-> (out_beat_o.vertex_slot == '0))
    else $error("overflow result with nonzero slot");
`endif

endmodule
